/* rtl/bsrm_pkg.sv */
// shared types and constants for the button-to-stick report mapper
// no dependencies
package bsrm_pkg;

  typedef struct packed {
    logic [7:0] whammy_raw;
    logic [7:0] action_keys;
    logic [1:0] modifier_keys;
    logic [3:0] cstick_keys;
    logic [3:0] direction_keys;
  } bsrm_in_t;

  typedef struct packed {
    logic [7:0] button_bits;
    logic [3:0] dpad_bits;
    logic [7:0] trigger_right;
    logic [7:0] trigger_left;
    logic [7:0] cstick_y;
    logic [7:0] cstick_x;
    logic [7:0] main_y;
    logic [7:0] main_x;
  } bsrm_out_t;

  // configuration register indexes
  localparam logic [2:0] REG_BAN_PARASOL   = 3'd0;
  localparam logic [2:0] REG_BAN_SIDE_SPEC = 3'd1;
  localparam logic [2:0] REG_WHAMMY_HIGH   = 3'd2;
  localparam logic [2:0] REG_WHAMMY_LOW    = 3'd3;
  localparam logic [2:0] REG_WHAMMY_DZ     = 3'd4;

  localparam logic [7:0] TRIGGER_FULL = 8'd140;
  localparam logic [7:0] WHAMMY_MAX   = 8'd255;
  localparam int         DIV_STEPS    = 16;

  // command from controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
  } bsrm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
  } bsrm_sts_t;

endpackage

/* rtl/button_to_stick_report_mapper.sv */
// top level: config registers, controller and datapath
// depends on bsrm_pkg, bsrm_ctrl, bsrm_dp
//
// One scan item in, one report item out. An item goes from accept through the
// divide and done states to out_valid. A clamped whammy value needs no quotient
// bits; for a scaled one, the 16-bit restoring divider retires one quotient
// bit a cycle. One item is in flight at a time; the next is accepted once the
// report has been taken. in_ready and cfg_ready stay low while reset is held.
module button_to_stick_report_mapper
  import bsrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bsrm_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bsrm_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       ban_parasol_r, ban_side_spec_r;
  logic [7:0] whammy_high_r, whammy_low_r, whammy_dz_r;
  bsrm_cmd_t  cmd;
  bsrm_sts_t  sts;

  assign cfg_ready = rst_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ban_parasol_r   <= 1'b0;
      ban_side_spec_r <= 1'b0;
      whammy_high_r   <= 8'd255;
      whammy_low_r    <= 8'd0;
      whammy_dz_r     <= 8'd13;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BAN_PARASOL:   ban_parasol_r   <= cfg_data[0];
        REG_BAN_SIDE_SPEC: ban_side_spec_r <= cfg_data[0];
        REG_WHAMMY_HIGH:   whammy_high_r   <= cfg_data;
        REG_WHAMMY_LOW:    whammy_low_r    <= cfg_data;
        REG_WHAMMY_DZ:     whammy_dz_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  bsrm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  bsrm_dp u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts,
    .ban_parasol   (ban_parasol_r),
    .ban_side_spec (ban_side_spec_r),
    .whammy_high   (whammy_high_r),
    .whammy_low    (whammy_low_r),
    .whammy_dz     (whammy_dz_r),
    .out_data
  );

endmodule

/* rtl/bsrm_ctrl.sv */
// controller: accept, divide sequencing, result hand-off
// depends on bsrm_pkg
module bsrm_ctrl
  import bsrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output bsrm_cmd_t cmd,
  input  bsrm_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t     state_r;
  logic [4:0] cnt_r;
  logic       out_valid_r;

  // no item is taken while reset is held
  assign in_ready     = rst_n && (state_r == S_IDLE) && !out_valid_r;
  assign out_valid    = out_valid_r;
  assign cmd.load     = in_valid && in_ready;
  assign cmd.div_step = (state_r == S_DIV);

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            state_r <= S_DIV;
            cnt_r   <= '0;
          end
        end
        S_DIV: begin
          if (!sts.need_div || cnt_r == 5'(DIV_STEPS - 1)) state_r <= S_DONE;
          cnt_r <= cnt_r + 5'd1;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result not presented");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < 5'(DIV_STEPS))) else $error("divide overrun");
`endif

endmodule

/* rtl/bsrm_dp.sv */
// datapath: lockout state, coordinate tables, whammy scaling with divider
// depends on bsrm_pkg
module bsrm_dp
  import bsrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bsrm_in_t   in_data,
  input  bsrm_cmd_t  cmd,
  output bsrm_sts_t  sts,
  input  logic       ban_parasol,
  input  logic       ban_side_spec,
  input  logic [7:0] whammy_high,
  input  logic [7:0] whammy_low,
  input  logic [7:0] whammy_dz,
  output bsrm_out_t  out_data
);

  logic [3:0] held_r, lock_r;
  logic [3:0] lock_nxt, eff;
  logic [7:0] kx, ky, cx, cy;
  logic       mir_x, mir_y, cmx, cmy;
  bsrm_out_t  res_r;

  // lockout update
  always_comb begin
    logic [3:0] r;
    r = in_data.direction_keys;
    lock_nxt = lock_r;
    if (held_r[0] && r[0] && r[1] && !held_r[1]) lock_nxt[0] = 1'b1;
    if (held_r[1] && r[0] && r[1] && !held_r[0]) lock_nxt[1] = 1'b1;
    if (held_r[2] && r[2] && r[3] && !held_r[3]) lock_nxt[2] = 1'b1;
    if (held_r[3] && r[2] && r[3] && !held_r[2]) lock_nxt[3] = 1'b1;
    lock_nxt = lock_nxt & r;
    eff = r & ~lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      lock_r <= '0;
    end else if (cmd.load) begin
      held_r <= in_data.direction_keys;
      lock_r <= lock_nxt;
    end
  end

  // main stick offset selection
  always_comb begin
    logic lf, rt, up, dn, mx, my, bb, bl, br, cl, cr, cu, cd, vert, horiz, rawlr;
    lf = eff[0]; rt = eff[1]; up = eff[2]; dn = eff[3];
    mx = in_data.modifier_keys[0]; my = in_data.modifier_keys[1];
    bb = in_data.action_keys[1]; bl = in_data.action_keys[5]; br = in_data.action_keys[6];
    cl = in_data.cstick_keys[0]; cr = in_data.cstick_keys[1];
    cu = in_data.cstick_keys[2]; cd = in_data.cstick_keys[3];
    vert = up || dn; horiz = lf || rt;
    rawlr = in_data.direction_keys[0] && in_data.direction_keys[1];
    kx = 8'd0; ky = 8'd0;
    if (vert && horiz) begin
      if (bl || br) begin
        if (mx == my) begin kx = 8'd56; ky = up ? 8'd56 : 8'd55; end
        else if (mx) begin kx = 8'd51; ky = 8'd30; end
        else if (ban_parasol && up) begin kx = 8'd38; ky = 8'd70; end
        else begin kx = 8'd40; ky = 8'd68; end
      end else if (bb && mx != my) begin
        if (mx) begin
          if (cd) begin kx = 8'd73; ky = 8'd36; end
          else if (cl) begin kx = 8'd68; ky = 8'd42; end
          else if (cu) begin kx = 8'd59; ky = 8'd43; end
          else if (cr) begin kx = 8'd51; ky = 8'd43; end
          else begin kx = 8'd73; ky = 8'd31; end
        end else begin
          if (cd) begin kx = 8'd36; ky = 8'd70; end
          else if (cl) begin kx = 8'd42; ky = 8'd68; end
          else if (cu) begin kx = 8'd47; ky = 8'd64; end
          else if (cr) begin kx = 8'd47; ky = 8'd57; end
          else begin kx = 8'd31; ky = 8'd73; end
        end
      end else if (mx != my) begin
        if (mx) begin
          if (cd) begin kx = 8'd56; ky = 8'd29; end
          else if (cl) begin kx = 8'd63; ky = 8'd39; end
          else if (cu) begin kx = 8'd56; ky = 8'd41; end
          else if (cr) begin kx = 8'd49; ky = 8'd42; end
          else begin kx = 8'd59; ky = 8'd25; end
        end else begin
          if (cd) begin kx = 8'd29; ky = 8'd56; end
          else if (cl) begin kx = 8'd39; ky = 8'd63; end
          else if (cu) begin kx = 8'd41; ky = 8'd56; end
          else if (cr) begin kx = 8'd51; ky = 8'd61; end
          else begin kx = 8'd25; ky = 8'd59; end
        end
      end else begin kx = 8'd56; ky = 8'd56; end
    end else if (horiz) begin
      if (mx == my) kx = 8'd80;
      else if (mx) kx = rawlr ? 8'd80 : 8'd53;
      else kx = ((ban_side_spec && bb) || rawlr) ? 8'd80 : 8'd27;
    end else if (vert) begin
      if (mx == my) ky = 8'd80;
      else if (mx) ky = 8'd43;
      else ky = 8'd59;
    end
    mir_x = horiz && !rt;
    mir_y = vert && !up;
    // c-stick
    cx = 8'd0; cy = 8'd0;
    if (mx && my) begin cx = 8'd0; cy = 8'd0; end
    else if ((cu != cd) && (cl != cr)) begin cx = 8'd42; cy = 8'd68; end
    else if (cl != cr) begin
      if (mx) begin cx = 8'd67; cy = up ? 8'd25 : 8'd231; end
      else cx = 8'd80;
    end else if (cu != cd) cy = 8'd80;
    cmx = (cl != cr) && cl;
    cmy = (cu != cd) && cd;
  end

  // whammy scaling setup
  logic        inv, w_fixed;
  logic [7:0]  lo, hi, w_const, act_v;
  logic [15:0] num_v;
  always_comb begin
    logic signed [9:0] thr;
    logic [7:0] t, r;
    r   = in_data.whammy_raw;
    inv = whammy_low > whammy_high;
    lo  = inv ? whammy_high : whammy_low;
    hi  = inv ? whammy_low : whammy_high;
    thr = $signed({2'b00, hi}) - $signed({2'b00, whammy_dz});
    t   = lo + whammy_dz;
    w_fixed = 1'b1; w_const = 8'd0; act_v = 8'd1; num_v = '0;
    if (inv) begin
      if ($signed({2'b00, r}) >= thr) w_const = 8'd0;
      else if (r <= lo) w_const = WHAMMY_MAX;
      else begin
        act_v = hi - whammy_dz - lo;
        if (act_v != 8'd0) begin
          w_fixed = 1'b0;
          num_v   = (16'(hi) - 16'(whammy_dz) - 16'(r)) * 16'd255;
        end
      end
    end else begin
      if (r <= t) w_const = 8'd0;
      else if (r >= hi) w_const = WHAMMY_MAX;
      else begin
        act_v = hi - t;
        if (act_v != 8'd0) begin
          w_fixed = 1'b0;
          num_v   = (16'(r) - 16'(t)) * 16'd255;
        end
      end
    end
  end

  // restoring divider, one quotient bit a step
  logic [15:0] quo_r;
  logic [8:0]  rem_r;
  logic [7:0]  dvs_r;
  logic        fixed_r;
  logic [8:0]  rem_sh;
  assign rem_sh = {rem_r[7:0], quo_r[15]};
  assign sts.need_div = !fixed_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fixed_r <= w_fixed;
      quo_r   <= num_v;
      rem_r   <= '0;
      dvs_r   <= act_v;
      res_r.main_x        <= mir_x ? 8'd0 - (8'd128 + kx) : 8'd128 + kx;
      res_r.main_y        <= mir_y ? 8'd0 - (8'd128 + ky) : 8'd128 + ky;
      res_r.cstick_x      <= cmx ? 8'd128 - cx : 8'd128 + cx;
      res_r.cstick_y      <= cmy ? 8'd128 - cy : 8'd128 + cy;
      res_r.trigger_left  <= in_data.action_keys[5] ? TRIGGER_FULL : 8'd0;
      res_r.trigger_right <= in_data.action_keys[6] ? TRIGGER_FULL : w_const;
      res_r.dpad_bits     <= (&in_data.modifier_keys) ? in_data.cstick_keys : 4'd0;
      res_r.button_bits   <= in_data.action_keys;
    end else if (cmd.div_step && !fixed_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= rem_sh - {1'b0, dvs_r};
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    out_data = res_r;
    if (!fixed_r && !res_r.button_bits[6]) out_data.trigger_right = quo_r[7:0];
  end

`ifndef ASSERT_OFF
  a_lock_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (lock_r & ~held_r) == 4'd0) else $error("lock on released key");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && !fixed_r) |-> (rem_r < {1'b0, dvs_r})) else $error("remainder");
  a_trig_l: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load) |-> (res_r.trigger_left == 8'd0 || res_r.trigger_left == TRIGGER_FULL))
    else $error("trigger left");
`endif

endmodule

/* tb/sv/tb_button_to_stick_report_mapper.sv */
// testbench for button_to_stick_report_mapper: random and directed scans, class scoreboard
// depends on bsrm_pkg and the mapper rtl
`timescale 1ns / 100ps

module tb_button_to_stick_report_mapper;
  import bsrm_pkg::*;

  // report predictor and queue of expected reports
  class report_board;
    bit       ban_parasol, ban_side;
    bit [7:0] w_high, w_low, w_dz;
    bit [3:0] held_dirs, lock_dirs;
    bsrm_out_t pending[$];
    int errors;

    function new();
      ban_parasol = 0; ban_side = 0;
      w_high = 8'd255; w_low = 8'd0; w_dz = 8'd13;
      held_dirs = 0; lock_dirs = 0; errors = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [7:0] val);
      case (idx)
        REG_BAN_PARASOL:   ban_parasol = val[0];
        REG_BAN_SIDE_SPEC: ban_side = val[0];
        REG_WHAMMY_HIGH:   w_high = val;
        REG_WHAMMY_LOW:    w_low = val;
        REG_WHAMMY_DZ:     w_dz = val;
        default: ;
      endcase
    endfunction

    function bit [7:0] whammy_scale(bit [7:0] raw);
      int lo, hi, dz, r, t, num;
      int unsigned span;
      lo = (w_low > w_high) ? w_high : w_low;
      hi = (w_low > w_high) ? w_low : w_high;
      dz = w_dz;
      r = raw;
      if (w_low > w_high) begin
        if (r >= hi - dz) return 0;
        if (r <= lo) return 255;
        span = (hi - dz - lo) & 255;
        num = (hi - dz - r) & 16'hffff;
      end else begin
        t = (lo + dz) & 255;
        if (r <= t) return 0;
        if (r >= hi) return 255;
        span = (hi - t) & 255;
        num = (r - t) & 16'hffff;
      end
      if (span == 0) return 0;
      return 8'((num * 255) / span);
    endfunction

    function bit [7:0] coord(int k);
      return 8'(128 + k);
    endfunction

    function void note_scan(bsrm_in_t s);
      bit [3:0] raw, lk, eff;
      bit l, r, u, d, mx, my, bb, bl, br, cl, cr, cu, cd, vert, horiz, rawlr, cv, ch;
      int kx, ky, cx, cy;
      bsrm_out_t e;
      raw = s.direction_keys;
      lk = lock_dirs;
      if (held_dirs[0] && raw[0] && raw[1] && !held_dirs[1]) lk[0] = 1;
      if (held_dirs[1] && raw[0] && raw[1] && !held_dirs[0]) lk[1] = 1;
      if (held_dirs[2] && raw[2] && raw[3] && !held_dirs[3]) lk[2] = 1;
      if (held_dirs[3] && raw[2] && raw[3] && !held_dirs[2]) lk[3] = 1;
      lk &= raw;
      lock_dirs = lk;
      held_dirs = raw;
      eff = raw & ~lk;
      {d, u, r, l} = eff;
      {my, mx} = s.modifier_keys;
      bb = s.action_keys[1]; bl = s.action_keys[5]; br = s.action_keys[6];
      {cd, cu, cr, cl} = s.cstick_keys;
      vert = u || d; horiz = l || r; rawlr = raw[0] && raw[1];
      if (vert && horiz) begin
        if (bl || br) begin
          if (mx == my) begin kx = 56; ky = u ? 56 : 55; end
          else if (mx) begin kx = 51; ky = 30; end
          else if (ban_parasol && u) begin kx = 38; ky = 70; end
          else begin kx = 40; ky = 68; end
        end else if (bb && mx != my) begin
          if (mx) begin
            if (cd) begin kx = 73; ky = 36; end
            else if (cl) begin kx = 68; ky = 42; end
            else if (cu) begin kx = 59; ky = 43; end
            else if (cr) begin kx = 51; ky = 43; end
            else begin kx = 73; ky = 31; end
          end else begin
            if (cd) begin kx = 36; ky = 70; end
            else if (cl) begin kx = 42; ky = 68; end
            else if (cu) begin kx = 47; ky = 64; end
            else if (cr) begin kx = 47; ky = 57; end
            else begin kx = 31; ky = 73; end
          end
        end else if (mx != my) begin
          if (mx) begin
            if (cd) begin kx = 56; ky = 29; end
            else if (cl) begin kx = 63; ky = 39; end
            else if (cu) begin kx = 56; ky = 41; end
            else if (cr) begin kx = 49; ky = 42; end
            else begin kx = 59; ky = 25; end
          end else begin
            if (cd) begin kx = 29; ky = 56; end
            else if (cl) begin kx = 39; ky = 63; end
            else if (cu) begin kx = 41; ky = 56; end
            else if (cr) begin kx = 51; ky = 61; end
            else begin kx = 25; ky = 59; end
          end
        end else begin kx = 56; ky = 56; end
      end else if (horiz) begin
        ky = 0;
        if (mx == my) kx = 80;
        else if (mx) kx = rawlr ? 80 : 53;
        else kx = ((ban_side && bb) || rawlr) ? 80 : 27;
      end else if (vert) begin
        kx = 0;
        if (mx == my) ky = 80;
        else if (mx) ky = 43;
        else ky = 59;
      end else begin kx = 0; ky = 0; end
      if (horiz && !r) kx = -kx;
      if (vert && !u) ky = -ky;
      cv = cu != cd; ch = cl != cr;
      if (mx && my) begin cx = 0; cy = 0; end
      else if (cv && ch) begin cx = 42; cy = 68; end
      else if (ch) begin
        if (mx) begin cx = 67; cy = u ? 25 : -25; end
        else begin cx = 80; cy = 0; end
      end else if (cv) begin cx = 0; cy = 80; end
      else begin cx = 0; cy = 0; end
      if (ch && cl) cx = -cx;
      if (cv && cd) cy = -cy;
      e.main_x = coord(kx); e.main_y = coord(ky);
      e.cstick_x = coord(cx); e.cstick_y = coord(cy);
      e.trigger_left = bl ? TRIGGER_FULL : 8'd0;
      e.trigger_right = br ? TRIGGER_FULL : whammy_scale(s.whammy_raw);
      e.dpad_bits = (mx && my) ? s.cstick_keys : 4'd0;
      e.button_bits = s.action_keys;
      pending.push_back(e);
    endfunction

    function void check_report(bsrm_out_t got);
      bsrm_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected report %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.main_x !== e.main_x) show("main_x", e.main_x, got.main_x);
      if (got.main_y !== e.main_y) show("main_y", e.main_y, got.main_y);
      if (got.cstick_x !== e.cstick_x) show("cstick_x", e.cstick_x, got.cstick_x);
      if (got.cstick_y !== e.cstick_y) show("cstick_y", e.cstick_y, got.cstick_y);
      if (got.trigger_left !== e.trigger_left)
        show("trigger_left", e.trigger_left, got.trigger_left);
      if (got.trigger_right !== e.trigger_right)
        show("trigger_right", e.trigger_right, got.trigger_right);
      if (got.dpad_bits !== e.dpad_bits)
        show("dpad_bits", 8'(e.dpad_bits), 8'(got.dpad_bits));
      if (got.button_bits !== e.button_bits)
        show("button_bits", e.button_bits, got.button_bits);
    endfunction

    function void show(string fld, logic [7:0] e, logic [7:0] a);
      $display("%0t: %s expected %0d actual %0d", $time, fld, e, a);
      errors++;
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic in_ready, out_valid, cfg_ready;
  bsrm_in_t in_data = '0;
  bsrm_out_t out_data;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  report_board board = new();
  bit stall_free = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  button_to_stick_report_mapper i_dut (.*);

  // receiver: random back-pressure, check on each accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_report(out_data);
  end
  always @(negedge clk) begin
    out_ready <= stall_free || ($urandom_range(99) >= 15);
  end

  // valid stays up after the write; the next phase drops it
  task automatic write_cfg(bit [2:0] idx, bit [7:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
  endtask

  // valid drops only on an idle cycle or in drain, so back to back items
  // see one update per falling edge
  task automatic send_scan(bsrm_in_t s);
    while (!stall_free && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_data <= s;
    do @(posedge clk); while (!in_ready);
    board.note_scan(s);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic bsrm_in_t rand_scan();
    bsrm_in_t s;
    // fully random scan
    s = bsrm_in_t'($urandom);
    return s;
  endfunction

  task automatic random_phase(int n);
    bsrm_in_t s;
    bit [3:0] prev;
    cfg_valid <= 0;
    prev = 0;
    for (int i = 0; i < n; i++) begin
      stall_free = (i % 300) > 220;
      s = rand_scan();
      // often build on the previous direction so lockouts get exercised
      if ($urandom_range(99) < 60) s.direction_keys = prev | (4'd1 << $urandom_range(3));
      if ($urandom_range(99) < 15) s.direction_keys = 4'b0;
      prev = s.direction_keys;
      send_scan(s);
    end
    stall_free = 0;
  endtask

  initial begin
    bsrm_in_t s;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, lockouts both ways, modifiers, triggers
    s = '0; send_scan(s);
    s = '1; send_scan(s);
    s = '0; s.direction_keys = 4'b0001; send_scan(s);
    s.direction_keys = 4'b0011; send_scan(s);
    s.direction_keys = 4'b0010; send_scan(s);
    s.direction_keys = 4'b0011; send_scan(s);
    s.direction_keys = 4'b0100; send_scan(s);
    s.direction_keys = 4'b1100; send_scan(s);
    s.direction_keys = 4'b1000; send_scan(s);
    s.direction_keys = 4'b1100; send_scan(s);
    s = '0; s.direction_keys = 4'b0011; s.modifier_keys = 2'b01; send_scan(s);
    s.modifier_keys = 2'b10; send_scan(s);
    s = '0; s.cstick_keys = 4'b0011; s.direction_keys = 4'b0101; send_scan(s);
    s.modifier_keys = 2'b11; s.cstick_keys = 4'b1111; send_scan(s);
    s = '0; s.action_keys = 8'h60; s.direction_keys = 4'b0110;
    s.modifier_keys = 2'b10; send_scan(s);
    s = '0; s.action_keys = 8'h02; s.direction_keys = 4'b1001;
    s.modifier_keys = 2'b01; s.cstick_keys = 4'b1000; send_scan(s);
    s = '0; s.whammy_raw = 8'd13; send_scan(s);
    s.whammy_raw = 8'd14; send_scan(s);
    s.whammy_raw = 8'd254; send_scan(s);
    drain();

    random_phase(300);
    drain();
    // restricted diagonals and inverted whammy
    write_cfg(REG_BAN_PARASOL, 8'd1);
    write_cfg(REG_BAN_SIDE_SPEC, 8'd1);
    write_cfg(REG_WHAMMY_HIGH, 8'd20);
    write_cfg(REG_WHAMMY_LOW, 8'd230);
    write_cfg(REG_WHAMMY_DZ, 8'd0);
    random_phase(300);
    drain();
    // extremes: full-width deadzone, degenerate span, bad index
    write_cfg(REG_WHAMMY_HIGH, 8'd0);
    write_cfg(REG_WHAMMY_LOW, 8'd255);
    write_cfg(REG_WHAMMY_DZ, 8'd255);
    write_cfg(3'd7, 8'd55);
    random_phase(200);
    drain();
    write_cfg(REG_BAN_PARASOL, 8'd0);
    write_cfg(REG_WHAMMY_HIGH, 8'd200);
    write_cfg(REG_WHAMMY_LOW, 8'd100);
    write_cfg(REG_WHAMMY_DZ, 8'd200);
    random_phase(200);
    drain();
    write_cfg(REG_BAN_SIDE_SPEC, 8'd0);
    write_cfg(REG_WHAMMY_HIGH, 8'd180);
    write_cfg(REG_WHAMMY_LOW, 8'd40);
    write_cfg(REG_WHAMMY_DZ, 8'd10);
    random_phase(200);
    drain();
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/bsrm_pkg.sv
rtl/bsrm_ctrl.sv
rtl/bsrm_dp.sv
rtl/button_to_stick_report_mapper.sv
tb/sv/tb_button_to_stick_report_mapper.sv
